@@ design/arp_pkg.sv @@
// Package for the ARM relocation patcher: codes, widths and pipeline stage type.
package arp_pkg;

    localparam int S_TDATA_W = 200;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 40;

    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_PC24     = 4'd1;
    localparam logic [3:0] KIND_ABS32    = 4'd2;
    localparam logic [3:0] KIND_REL32    = 4'd3;
    localparam logic [3:0] KIND_ABS8     = 4'd4;
    localparam logic [3:0] KIND_ABS16    = 4'd5;
    localparam logic [3:0] KIND_ABS12    = 4'd6;
    localparam logic [3:0] KIND_THM_ABS5 = 4'd7;
    localparam logic [3:0] KIND_THM_PC22 = 4'd8;

    localparam logic [1:0] WS_NONE = 2'd0;
    localparam logic [1:0] WS_BYTE = 2'd1;
    localparam logic [1:0] WS_HALF = 2'd2;
    localparam logic [1:0] WS_WORD = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [31:0] PC24_TOP_MASK = 32'hff00_0000;
    localparam logic [31:0] ABS12_KEEP    = 32'hffff_f000;
    localparam logic [31:0] THM5_KEEP     = 32'h0000_f82f;
    localparam logic [31:0] PC22_FIELDS   = 32'h07ff_07ff;
    localparam logic [31:0] PC_BIAS       = 32'd8;

    typedef struct packed {
        logic [3:0]         kind;
        logic               thumb;
        logic               be;
        logic [31:0]        old;
        logic [31:0]        place;
        logic [31:0]        v;
        logic [31:0]        t1;
        logic [31:0]        t2;
        logic [31:0]        p;
        logic [31:0]        d;
        logic [31:0]        rel;
        logic signed [22:0] sadd;
        logic               ovf8;
        logic               ovf16;
        logic               ovf12;
        logic               ovf5;
        logic               ovf22;
    } pipe_t;

endpackage

@@ design/arm_relocation_patcher_top.sv @@
// Top level of the ARM relocation patcher: five-stage pipeline, one item per cycle while the result is not stalled.
//
//  channel | ports                              | contents
//  --------+------------------------------------+-------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser  | one relocation record
//  result  | m_tvalid m_tready m_tdata          | patched word, write size, status
//  config  | cfg_valid cfg_ready cfg_data       | big_endian register
//
// One item per cycle is sustained while the result is not stalled; the add/compare chain is
// split over four compute stages (st1 to st4) followed by the output register.
// Reset clears all stage valid bits and big_endian; payload registers are not reset.
// A stalled result freezes every stage together, so nothing is lost or repeated.
module arm_relocation_patcher_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] symbol_value, [63:32] addend, [95:64] place_offset,
    // [127:96] section_out_offset, [159:128] section_out_base,
    // [191:160] old_word, [192] target_is_thumb, [199:193] zero
    input  logic [arp_pkg::S_TDATA_W-1:0] s_tdata,
    // [3:0] req_type
    input  logic [arp_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] new_word, [33:32] write_size, [35:34] status, [39:36] zero
    output logic [arp_pkg::M_TDATA_W-1:0] m_tdata
);
    import arp_pkg::*;

    logic        big_endian_reg;
    logic        adv;
    logic [3:0]  valid_reg;
    pipe_t       st1_reg, st2_reg, st3_reg, st4_reg;
    pipe_t       st1_next, st2_next, st3_next, st4_next;
    logic        m_tvalid_reg;
    logic [31:0] word_reg, word_next;
    logic [1:0]  size_reg, size_next;
    logic [1:0]  status_reg, status_next;

    logic [31:0] in_sym, in_add, in_place, in_soff, in_sbase, in_old;
    logic [22:0] old_off;
    logic signed [32:0] chk;

    assign cfg_ready = aresetn;
    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv && aresetn;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'b0, status_reg, size_reg, word_reg};

    assign in_sym   = s_tdata[31:0];
    assign in_add   = s_tdata[63:32];
    assign in_place = s_tdata[95:64];
    assign in_soff  = s_tdata[127:96];
    assign in_sbase = s_tdata[159:128];
    assign in_old   = s_tdata[191:160];

    always_comb begin
        if (big_endian_reg) begin
            old_off = {in_old[26:16], in_old[10:0], 1'b0};
        end else begin
            old_off = {in_old[10:0], in_old[26:16], 1'b0};
        end
        st1_next       = st1_reg;
        st1_next.kind  = s_tuser[3:0];
        st1_next.thumb = s_tdata[192];
        st1_next.be    = big_endian_reg;
        st1_next.old   = in_old;
        st1_next.place = in_place;
        st1_next.v     = in_sym + in_add;
        st1_next.t1    = in_soff + in_place + PC_BIAS;
        st1_next.t2    = in_sbase + in_soff;
        st1_next.sadd  = $signed(old_off);
    end

    always_comb begin
        st2_next       = st1_reg;
        st2_next.p     = st1_reg.v - st1_reg.t1;
        st2_next.d     = st1_reg.v - st1_reg.t2;
        st2_next.ovf8  = !((st1_reg.v[31:7] == '0) || (st1_reg.v[31:7] == '1));
        st2_next.ovf16 = !((st1_reg.v[31:15] == '0) || (st1_reg.v[31:15] == '1));
        st2_next.ovf12 = !((st1_reg.v[31:11] == '0) || (st1_reg.v[31:11] == '1));
        st2_next.ovf5  = !((st1_reg.v[31:5] == '0) || (st1_reg.v[31:4] == '1));
    end

    always_comb begin
        st3_next     = st2_reg;
        st3_next.rel = st2_reg.d - st2_reg.place;
    end

    always_comb begin
        chk = $signed({st3_reg.rel[31], st3_reg.rel[31], st3_reg.rel[31:1]})
            + $signed({{10{st3_reg.sadd[22]}}, st3_reg.sadd});
        st4_next       = st3_reg;
        st4_next.rel   = st3_reg.rel + {{9{st3_reg.sadd[22]}}, st3_reg.sadd};
        st4_next.ovf22 = !((chk[32:21] == '0) || (chk[32:21] == '1));
    end

    always_comb begin
        word_next   = 32'd0;
        size_next   = WS_NONE;
        status_next = ST_OK;
        unique case (st4_reg.kind)
            KIND_NONE: begin
            end
            KIND_PC24: begin
                word_next = {8'b0, st4_reg.p[25:2]} | (st4_reg.old & PC24_TOP_MASK);
                size_next = WS_WORD;
            end
            KIND_ABS32: begin
                word_next = {st4_reg.v[31:1], st4_reg.v[0] | st4_reg.thumb};
                size_next = WS_WORD;
            end
            KIND_REL32: begin
                word_next = st4_reg.d;
                size_next = WS_WORD;
            end
            KIND_ABS8: begin
                if (st4_reg.ovf8) begin
                    status_next = ST_OVF;
                end else begin
                    word_next = {24'b0, st4_reg.v[7:0]};
                    size_next = WS_BYTE;
                end
            end
            KIND_ABS16: begin
                if (st4_reg.ovf16) begin
                    status_next = ST_OVF;
                end else begin
                    word_next = {16'b0, st4_reg.v[15:0]};
                    size_next = WS_HALF;
                end
            end
            KIND_ABS12: begin
                if (st4_reg.ovf12) begin
                    status_next = ST_OVF;
                end else begin
                    word_next = st4_reg.v | (st4_reg.old & ABS12_KEEP);
                    size_next = WS_WORD;
                end
            end
            KIND_THM_ABS5: begin
                if (st4_reg.ovf5) begin
                    status_next = ST_OVF;
                end else begin
                    word_next = {16'b0, st4_reg.v[15:0] | (st4_reg.old[15:0] & THM5_KEEP[15:0])};
                    size_next = WS_HALF;
                end
            end
            KIND_THM_PC22: begin
                if (st4_reg.be) begin
                    word_next = (st4_reg.old & ~PC22_FIELDS)
                              | {5'b0, st4_reg.rel[22:12], 5'b0, st4_reg.rel[11:1]};
                end else begin
                    word_next = (st4_reg.old & ~PC22_FIELDS)
                              | {5'b0, st4_reg.rel[11:1], 5'b0, st4_reg.rel[22:12]};
                end
                size_next = WS_WORD;
                if (st4_reg.ovf22) begin
                    status_next = ST_OVF;
                end
            end
            default: begin
                status_next = ST_UNSUP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b0;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                big_endian_reg <= cfg_data;
            end
            if (adv) begin
                valid_reg    <= {valid_reg[2:0], s_tvalid};
                m_tvalid_reg <= valid_reg[3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg    <= st1_next;
            st2_reg    <= st2_next;
            st3_reg    <= st3_next;
            st4_reg    <= st4_next;
            word_reg   <= word_next;
            size_reg   <= size_next;
            status_reg <= status_next;
        end
    end

endmodule
